>>> rtl/core/mfa_pkg.sv
// Shared types and constants for the Montgomery field ALU.
`timescale 1ns / 1ps
package mfa_pkg;

    localparam int LIMB_W = 64;
    localparam int W      = 256;
    localparam int DIG_W  = 32;
    localparam int NDIG   = W / DIG_W;
    localparam int MUL_LAT = 5;
    // Stages from request capture to response register.
    localparam int LAT     = 3 * MUL_LAT + 2;
    localparam int TDEL    = 2 * MUL_LAT;
    localparam int ASDEL   = LAT - 3;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_MUL  = 2'd2,
        CMD_RSVD = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOD_W0 = 4'd0,
        REG_MOD_W1 = 4'd1,
        REG_MOD_W2 = 4'd2,
        REG_MOD_W3 = 4'd3,
        REG_FAC_W0 = 4'd4,
        REG_FAC_W1 = 4'd5,
        REG_FAC_W2 = 4'd6,
        REG_FAC_W3 = 4'd7
    } t_reg_idx;

    typedef struct packed {
        t_cmd         cmd;
        logic [W-1:0] res;
    } t_as;

endpackage

>>> rtl/core/mfa_req_if.sv
// Request channel interface: command and two 256-bit operands.
`timescale 1ns / 1ps
interface mfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] a_w0;
    logic [63:0] a_w1;
    logic [63:0] a_w2;
    logic [63:0] a_w3;
    logic [63:0] b_w0;
    logic [63:0] b_w1;
    logic [63:0] b_w2;
    logic [63:0] b_w3;
    modport source (output valid, cmd, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
                    input ready);
    modport sink (input valid, cmd, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
                  output ready);
endinterface

>>> rtl/core/mfa_rsp_if.sv
// Response channel interface: one 256-bit result.
`timescale 1ns / 1ps
interface mfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] r_w0;
    logic [63:0] r_w1;
    logic [63:0] r_w2;
    logic [63:0] r_w3;
    modport source (output valid, r_w0, r_w1, r_w2, r_w3, input ready);
    modport sink (input valid, r_w0, r_w1, r_w2, r_w3, output ready);
endinterface

>>> rtl/core/mfa_mul256.sv
// Pipelined 256x256 multiplier: 32x32 partial products, then a registered adder tree.
`timescale 1ns / 1ps
module mfa_mul256 import mfa_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_x,
    input  logic [W-1:0]   i_y,
    output logic [2*W-1:0] o_p
);

    logic [2*DIG_W-1:0] r_pp [NDIG][NDIG];
    logic [2*W-1:0]     w_row [2*NDIG];
    logic [2*W-1:0]     r_s1 [NDIG];
    logic [2*W-1:0]     r_s2 [NDIG/2];
    logic [2*W-1:0]     r_s3 [NDIG/4];
    logic [2*W-1:0]     r_s4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NDIG; i++) begin
                for (int j = 0; j < NDIG; j++) begin
                    r_pp[i][j] <= (2*DIG_W)'(i_x[DIG_W*i +: DIG_W])
                                * (2*DIG_W)'(i_y[DIG_W*j +: DIG_W]);
                end
            end
        end
    end

    // Products of one row with same-parity column never overlap: pack them.
    always_comb begin
        for (int k = 0; k < 2*NDIG; k++) begin
            w_row[k] = '0;
        end
        for (int i = 0; i < NDIG; i++) begin
            for (int j = 0; j < NDIG; j++) begin
                w_row[2*i + (j % 2)] = w_row[2*i + (j % 2)]
                    | ((2*W)'(r_pp[i][j]) << (DIG_W*(i+j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NDIG; k++) begin
                r_s1[k] <= w_row[2*k] + w_row[2*k+1];
            end
            for (int k = 0; k < NDIG/2; k++) begin
                r_s2[k] <= r_s1[2*k] + r_s1[2*k+1];
            end
            for (int k = 0; k < NDIG/4; k++) begin
                r_s3[k] <= r_s2[2*k] + r_s2[2*k+1];
            end
            r_s4 <= r_s3[0] + r_s3[1];
        end
    end

    assign o_p = r_s4;

endmodule

>>> rtl/core/mfa_addsub.sv
// Two-stage modular add / subtract with one correction.
`timescale 1ns / 1ps
module mfa_addsub import mfa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  t_cmd         i_cmd,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_p,
    output t_as          o_as
);

    t_cmd         r_cmd;
    logic [W:0]   r_sum;
    logic [W:0]   r_dif;
    t_as          w_res;
    logic [W+1:0] w_red;
    logic [W-1:0] w_fix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd <= i_cmd;
            r_sum <= {1'b0, i_a} + {1'b0, i_b};
            r_dif <= {1'b0, i_a} - {1'b0, i_b};
        end
    end

    // 257-bit sum minus p; no borrow means sum was not below p.
    assign w_red = {1'b0, r_sum} - {2'b00, i_p};
    assign w_fix = r_dif[W-1:0] + i_p;

    always_comb begin
        w_res.cmd = r_cmd;
        case (r_cmd)
            CMD_ADD: w_res.res = w_red[W+1] ? r_sum[W-1:0] : w_red[W-1:0];
            CMD_SUB: w_res.res = r_dif[W] ? w_fix : r_dif[W-1:0];
            default: w_res.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_as <= w_res;
        end
    end

endmodule

>>> rtl/core/montgomery_field_alu_256.sv
// Top level of the 256-bit Montgomery prime-field ALU.
// Usage:
//   Requests enter on i_req (cmd, a_w0..a_w3, b_w0..b_w3) with a valid/ready
//   handshake; results leave on o_rsp (r_w0..r_w3), one per request, in order.
//   cmd: add, subtract a minus b, Montgomery multiply; the unused code yields 0.
//   Modulus and Montgomery factor are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data (indexes 0..3 modulus words, 4..7 factor words) while idle.
// Timing:
//   Latency is the same for all codes: every request, whatever its cmd,
//   passes through every register stage before its result is valid.
//   Throughput is one request per cycle unless stalled: the multiply is three
//   5-stage 32x32-digit multiplier pipelines in series, plus a final add and a
//   conditional subtract stage (17 register stages, the first loaded at accept).
// Reset (synchronous, active low) clears the pipeline valid bits and the
//   configuration registers.
// Stall: when the result is not taken, the whole pipeline holds and i_req.ready
//   drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module montgomery_field_alu_256 import mfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mfa_req_if.sink              i_req,
    mfa_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMB_W-1:0]    i_cfg_data
);

    logic [W-1:0]   r_mod;
    logic [W-1:0]   r_fac;
    logic [LAT-1:0] r_vld;
    logic           w_en;
    logic [W-1:0]   w_a;
    logic [W-1:0]   w_b;
    logic [2*W-1:0] w_t;
    logic [2*W-1:0] w_m;
    logic [2*W-1:0] w_mp;
    logic [2*W-1:0] r_tdel [TDEL];
    t_as            w_as;
    t_as            r_asdel [ASDEL];
    logic [W:0]     r_hi;
    logic [2*W:0]   w_s;
    logic [W+1:0]   w_d;
    logic [W-1:0]   r_out;

    assign w_en = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign w_a = {i_req.a_w3, i_req.a_w2, i_req.a_w1, i_req.a_w0};
    assign w_b = {i_req.b_w3, i_req.b_w2, i_req.b_w1, i_req.b_w0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
            r_fac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOD_W0: r_mod[0*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_MOD_W1: r_mod[1*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_MOD_W2: r_mod[2*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_MOD_W3: r_mod[3*LIMB_W +: LIMB_W] <= {1'b0, i_cfg_data[LIMB_W-2:0]};
                REG_FAC_W0: r_fac[0*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_FAC_W1: r_fac[1*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_FAC_W2: r_fac[2*LIMB_W +: LIMB_W] <= i_cfg_data;
                REG_FAC_W3: r_fac[3*LIMB_W +: LIMB_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // T = a*b, m = T*factor mod 2^256, m*p
    mfa_mul256 u_mul_ab (.i_clk(i_clk), .i_en(w_en), .i_x(w_a), .i_y(w_b), .o_p(w_t));
    mfa_mul256 u_mul_m (.i_clk(i_clk), .i_en(w_en), .i_x(w_t[W-1:0]), .i_y(r_fac),
                        .o_p(w_m));
    mfa_mul256 u_mul_mp (.i_clk(i_clk), .i_en(w_en), .i_x(w_m[W-1:0]), .i_y(r_mod),
                         .o_p(w_mp));

    mfa_addsub u_addsub (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cmd (t_cmd'(i_req.cmd)),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_p   (r_mod),
        .o_as  (w_as)
    );

    assign w_s = {1'b0, r_tdel[TDEL-1]} + {1'b0, w_mp};
    assign w_d = {1'b0, r_hi} - {2'b00, r_mod};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdel[0] <= w_t;
            for (int k = 1; k < TDEL; k++) begin
                r_tdel[k] <= r_tdel[k-1];
            end
            r_asdel[0] <= w_as;
            for (int k = 1; k < ASDEL; k++) begin
                r_asdel[k] <= r_asdel[k-1];
            end
            r_hi <= w_s[2*W:W];
            if (r_asdel[ASDEL-1].cmd == CMD_MUL) begin
                r_out <= w_d[W+1] ? r_hi[W-1:0] : w_d[W-1:0];
            end else begin
                r_out <= r_asdel[ASDEL-1].res;
            end
        end
    end

    assign o_rsp.valid = r_vld[LAT-1];
    assign o_rsp.r_w0  = r_out[0*LIMB_W +: LIMB_W];
    assign o_rsp.r_w1  = r_out[1*LIMB_W +: LIMB_W];
    assign o_rsp.r_w2  = r_out[2*LIMB_W +: LIMB_W];
    assign o_rsp.r_w3  = r_out[3*LIMB_W +: LIMB_W];

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during stall");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request not captured");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid after reset");
    a_modulus_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mod[W-1])
        else $error("modulus top bit set");
`endif

endmodule
